// ----- rtl/bped_pkg.sv -----
package bped_pkg;

    // buttons in the design, and pin bits carried by one scan tick
    localparam int NUM_BUTTONS = 8;
    localparam int PIN_BITS    = 8;

    // buttons that can ever be looked at
    localparam int DEPTH   = (NUM_BUTTONS < PIN_BITS) ? NUM_BUTTONS : PIN_BITS;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = 4;
    localparam int CNT_W   = 17;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_LONG    = 2'd1,
        EV_RELEASE = 2'd2
    } ev_kind_t;

    typedef enum logic [3:0] {
        REG_BUTTON_COUNT     = 4'd0,
        REG_ACTIVE_LEVELS    = 4'd1,
        REG_SCAN_INTERVAL    = 4'd2,
        REG_LONG_PRESS_DELAY = 4'd3
    } reg_idx_t;

    typedef enum logic {
        SCAN_IDLE,
        SCAN_RUN
    } scan_state_t;

    // one entry of the state memory
    typedef struct packed {
        logic             pressed;
        logic [CNT_W-1:0] cnt;
    } btn_state_t;

    // one processed button, handed from the scanner to the event stage
    typedef struct packed {
        logic             has_ev;
        logic [IDX_W-1:0] idx;
        ev_kind_t         kind;
        logic             last;
    } bped_step_t;

endpackage

// ----- rtl/bped_state_ram.sv -----
module bped_state_ram
    import bped_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  btn_state_t       wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output btn_state_t       rd_data
);

    btn_state_t       mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    btn_state_t       rd_data_reg;
    logic             rd_written_reg;

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-entry written flags, so a fresh entry reads as the reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/bped_scan.sv -----
module bped_scan
    import bped_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick_vld,
    input  logic [DEPTH-1:0]   tick_pins,
    input  logic [COUNT_W-1:0] count_eff,
    input  logic [DEPTH-1:0]   levels,
    input  logic [7:0]         interval,
    input  logic [15:0]        delay,
    output logic               busy,
    output logic               step_vld,
    output bped_step_t         step,
    input  logic               step_rdy,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output btn_state_t         wr_data,
    output logic               rd_en,
    output logic [IDX_W-1:0]   rd_addr,
    input  btn_state_t         rd_data
);

    scan_state_t        state_reg;
    scan_state_t        state_next;
    logic [COUNT_W-1:0] nxt_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DEPTH-1:0]   pins_reg;
    logic               s1_vld_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_end_reg;
    logic               adv;
    logic               issue_ok;
    logic               active;
    logic [CNT_W-1:0]   sum;

    assign adv      = !s1_vld_reg || step_rdy;
    assign issue_ok = (state_reg == SCAN_RUN) && (nxt_reg < count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SCAN_IDLE:
            begin
                if (tick_vld)
                begin
                    state_next = SCAN_RUN;
                end
            end
            SCAN_RUN:
            begin
                if (adv && !issue_ok)
                begin
                    state_next = SCAN_IDLE;
                end
            end
            default: state_next = SCAN_IDLE;
        endcase
    end

    always_comb
    begin
        rd_en   = adv && issue_ok;
        rd_addr = nxt_reg[IDX_W-1:0];
        busy    = (state_reg != SCAN_IDLE) || s1_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SCAN_IDLE;
            nxt_reg    <= '0;
            count_reg  <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (tick_vld)
            begin
                nxt_reg   <= '0;
                count_reg <= count_eff;
            end
            else if (rd_en)
            begin
                nxt_reg <= nxt_reg + COUNT_W'(1);
            end
            if (adv)
            begin
                s1_vld_reg <= rd_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_vld)
        begin
            pins_reg <= tick_pins;
        end
        if (adv)
        begin
            s1_idx_reg <= rd_addr;
            s1_end_reg <= ((nxt_reg + COUNT_W'(1)) == count_reg);
        end
    end

    // read-modify-write of the button entry that came out of memory
    assign active = (pins_reg[s1_idx_reg] == levels[s1_idx_reg]);
    assign sum    = rd_data.cnt + CNT_W'(interval);

    always_comb
    begin
        wr_data     = rd_data;
        step.has_ev = 1'b0;
        step.kind   = EV_PRESS;
        step.idx    = s1_idx_reg;
        step.last   = s1_end_reg;
        priority if (active && rd_data.pressed)
        begin
            if (sum >= {1'b0, delay})
            begin
                wr_data.cnt = '0;
                step.has_ev = 1'b1;
                step.kind   = EV_LONG;
            end
            else
            begin
                wr_data.cnt = sum;
            end
        end
        else if (active)
        begin
            wr_data.pressed = 1'b1;
            wr_data.cnt     = '0;
            step.has_ev     = 1'b1;
            step.kind       = EV_PRESS;
        end
        else if (rd_data.pressed)
        begin
            wr_data.pressed = 1'b0;
            step.has_ev     = 1'b1;
            step.kind       = EV_RELEASE;
        end
    end

    assign step_vld = s1_vld_reg;
    assign wr_en    = s1_vld_reg && step_rdy;
    assign wr_addr  = s1_idx_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> (COUNT_W'(s1_idx_reg) < count_reg))
        else $error("button processed beyond count");

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !wr_data.cnt[CNT_W-1])
        else $error("stored hold counter reached 65536");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && !step_rdy) |=> (s1_vld_reg && $stable(s1_idx_reg)))
        else $error("stalled button lost");

endmodule

// ----- rtl/bped_out.sv -----
module bped_out
    import bped_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_vld,
    input  bped_step_t step,
    output logic       step_rdy,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] button_index,
    output logic [1:0] event_kind,
    output logic       last
);

    logic             pend_vld_reg;
    logic             pend_last_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    ev_kind_t         pend_kind_reg;
    logic             out_vld_reg;
    logic [2:0]       out_idx_reg;
    ev_kind_t         out_kind_reg;
    logic             out_last_reg;
    logic             out_free;
    logic             new_ev;
    logic             move;

    // one event is held back until the next one (or the tick end) shows its last flag
    assign out_free = !out_vld_reg || !out_stall;
    assign new_ev   = step_vld && step.has_ev;
    assign step_rdy = !step.has_ev || !pend_vld_reg || out_free;
    assign move     = pend_vld_reg && out_free && (pend_last_reg || new_ev);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg  <= 1'b0;
            pend_last_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (new_ev && step_rdy)
            begin
                pend_vld_reg  <= 1'b1;
                pend_last_reg <= step.last;
            end
            else
            begin
                if (move)
                begin
                    pend_vld_reg <= 1'b0;
                end
                // only an eventless tick end marks the held event as final
                if (step_vld && !step.has_ev && step.last)
                begin
                    pend_last_reg <= 1'b1;
                end
            end
            if (move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (new_ev && step_rdy)
        begin
            pend_idx_reg  <= step.idx;
            pend_kind_reg <= step.kind;
        end
        if (move)
        begin
            out_idx_reg  <= 3'(pend_idx_reg);
            out_kind_reg <= pend_kind_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign out_valid    = out_vld_reg;
    assign button_index = out_idx_reg;
    assign event_kind   = out_kind_reg;
    assign last         = out_last_reg;

    a_event_held: assert property (@(posedge clk) disable iff (!rst_n)
        (new_ev && step_rdy) |=> pend_vld_reg)
        else $error("accepted event not held");

endmodule

// ----- rtl/button_press_event_detector_core.sv -----
// button press / long-press / release detector. each transfer on the input
// channel is one scan tick carrying the raw pin levels of up to eight buttons.
// buttons below button_count are walked in index order; per button one event
// at most comes out: press when the pin first matches its active level,
// long press each time the hold counter (grown by scan_interval per held tick)
// reaches long_press_delay, release when a pressed button lets go. the final
// event of a tick carries last; a tick with no events gives no transfer.
// button state (pressed flag and 17-bit hold counter) lives in a small
// single-read-port memory that is read, updated and written back one button
// per cycle while the result side does not stall; input stall stays high for
// the whole walk. output stalls hold the walk in place. state entries clear at
// reset through per-entry written flags, so no clearing pass is needed.
// configuration writes must happen only while the block is idle.
module button_press_event_detector_core
    import bped_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // scan tick input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pin_levels,
    // event output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  button_index,
    output logic [1:0]  event_kind,
    output logic        last
);

    logic [COUNT_W-1:0] button_count_reg;
    logic [7:0]         active_levels_reg;
    logic [7:0]         scan_interval_reg;
    logic [15:0]        long_press_delay_reg;
    logic [COUNT_W-1:0] count_eff;
    logic               in_xfer;
    logic               busy;
    logic               step_vld;
    bped_step_t         step;
    logic               step_rdy;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    btn_state_t         wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    btn_state_t         rd_data;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg     <= COUNT_W'(8);
            active_levels_reg    <= 8'd0;
            scan_interval_reg    <= 8'd10;
            long_press_delay_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BUTTON_COUNT)
            begin
                button_count_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cfg_index == REG_ACTIVE_LEVELS)
            begin
                active_levels_reg <= cfg_data[7:0];
            end
            if (cfg_index == REG_SCAN_INTERVAL)
            begin
                scan_interval_reg <= cfg_data[7:0];
            end
            if (cfg_index == REG_LONG_PRESS_DELAY)
            begin
                long_press_delay_reg <= cfg_data;
            end
        end
    end

    // saturate the count to the buttons that exist
    assign count_eff = (button_count_reg > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH)
                                                            : button_count_reg;

    // a new tick waits until the previous walk has finished
    assign in_stall = busy;
    assign in_xfer  = in_valid && !in_stall;

    bped_state_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bped_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_vld  (in_xfer),
        .tick_pins (pin_levels[DEPTH-1:0]),
        .count_eff (count_eff),
        .levels    (active_levels_reg[DEPTH-1:0]),
        .interval  (scan_interval_reg),
        .delay     (long_press_delay_reg),
        .busy      (busy),
        .step_vld  (step_vld),
        .step      (step),
        .step_rdy  (step_rdy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    bped_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_vld     (step_vld),
        .step         (step),
        .step_rdy     (step_rdy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .button_index (button_index),
        .event_kind   (event_kind),
        .last         (last)
    );

    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("second tick accepted during walk");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

// tracks pressed flags and hold counters per button and keeps the queue of
// events that the block owes for every accepted scan tick
class button_event_tracker;

    typedef struct {
        logic [2:0]              idx;
        bped_pkg::ev_kind_t      kind;
        logic                    fin;
    } press_event_t;

    logic [3:0]  count_reg;
    logic [7:0]  level_reg;
    logic [7:0]  step_reg;
    logic [15:0] delay_reg;

    bit          held[bped_pkg::DEPTH];
    logic [16:0] hold_cnt[bped_pkg::DEPTH];

    press_event_t owed_events[$];
    int           errors;

    function new();
        count_reg = 4'd8;
        level_reg = 8'd0;
        step_reg  = 8'd10;
        delay_reg = 16'd1000;
        errors    = 0;
        for (int i = 0; i < bped_pkg::DEPTH; i++)
        begin
            held[i]     = 1'b0;
            hold_cnt[i] = '0;
        end
    endfunction

    function void write_reg(logic [3:0] index, logic [15:0] value);
        case (index)
            bped_pkg::REG_BUTTON_COUNT:     count_reg = value[3:0];
            bped_pkg::REG_ACTIVE_LEVELS:    level_reg = value[7:0];
            bped_pkg::REG_SCAN_INTERVAL:    step_reg  = value[7:0];
            bped_pkg::REG_LONG_PRESS_DELAY: delay_reg = value;
            default: ;
        endcase
    endfunction

    function void push_event(int i, bped_pkg::ev_kind_t kind);
        press_event_t ev;
        ev.idx  = i[2:0];
        ev.kind = kind;
        ev.fin  = 1'b0;
        owed_events.push_back(ev);
    endfunction

    function void note_scan(logic [7:0] pins);
        int          used;
        int          start_size;
        logic [16:0] sum;
        used       = (int'(count_reg) > bped_pkg::DEPTH) ? bped_pkg::DEPTH : int'(count_reg);
        start_size = owed_events.size();
        for (int i = 0; i < used; i++)
        begin
            if (pins[i] == level_reg[i])
            begin
                if (held[i])
                begin
                    sum = hold_cnt[i] + {9'd0, step_reg};
                    if (sum >= {1'b0, delay_reg})
                    begin
                        sum = '0;
                        push_event(i, bped_pkg::EV_LONG);
                    end
                    hold_cnt[i] = sum;
                end
                else
                begin
                    held[i]     = 1'b1;
                    hold_cnt[i] = '0;
                    push_event(i, bped_pkg::EV_PRESS);
                end
            end
            else if (held[i])
            begin
                held[i] = 1'b0;
                push_event(i, bped_pkg::EV_RELEASE);
            end
        end
        if (owed_events.size() > start_size)
            owed_events[owed_events.size() - 1].fin = 1'b1;
    endfunction

    function void check_event(logic [2:0] idx, logic [1:0] kind, logic fin);
        press_event_t ev;
        if (owed_events.size() == 0)
        begin
            $error("unexpected event: button_index %0d event_kind %0d last %0d",
                   idx, kind, fin);
            errors++;
            return;
        end
        ev = owed_events.pop_front();
        if (idx !== ev.idx)
        begin
            $error("button_index mismatch: expected %0d, actual %0d", ev.idx, idx);
            errors++;
        end
        if (kind !== ev.kind)
        begin
            $error("event_kind mismatch: expected %0d, actual %0d", ev.kind, kind);
            errors++;
        end
        if (fin !== ev.fin)
        begin
            $error("last mismatch: expected %0d, actual %0d", ev.fin, fin);
            errors++;
        end
    endfunction

    function int pending();
        return owed_events.size();
    endfunction

endclass

module tb_top;
    import bped_pkg::*;

    // index with no register behind it, written now and then to see it ignored
    localparam logic [3:0] REG_SPARE = 4'd12;
    // cycles for the last tick walk to finish before config changes
    localparam int SETTLE_CYCLES = 16;
    // cycles with no transfer on either channel before giving up
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_index = 4'd0;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  pin_levels = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  button_index;
    logic [1:0]  event_kind;
    logic        last;

    button_event_tracker tracker = new();

    // input side idling mode, chosen per phase
    bit          no_gaps = 1'b0;
    // pin levels of the previous tick, random ticks mostly drift from here
    logic [7:0]  prev_pins = 8'd0;
    int          idle_cycles = 0;
    int          stall_run = 0;

    always #6 clk = ~clk;

    button_press_event_detector_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_levels   (pin_levels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .button_index (button_index),
        .event_kind   (event_kind),
        .last         (last)
    );

    // result side stall pattern: short stalls mostly, a few long ones,
    // and long stretches with no stall at all
    always @(posedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run = stall_run - 1;
        end
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 8);
        end
        else
        begin
            out_stall <= 1'b1;
            stall_run = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 2);
        end
    end

    // every output transfer is checked against the oldest owed event
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            tracker.check_event(button_index, event_kind, last);
    end

    // cycles since the last transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // one scan tick transfer; valid stays high into the next tick when no gap
    task automatic send_tick(input logic [7:0] pins);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= pins;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.note_scan(pins);
        prev_pins = pins;
    endtask

    // wait for every owed event, then let any eventless walk finish
    task automatic drain_events();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [3:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        tracker.write_reg(index, value);
    endtask

    task automatic apply_config(input logic [3:0] count, input logic [7:0] levels,
                                input logic [7:0] step, input logic [15:0] delay_val,
                                input bit spare);
        drain_events();
        cfg_write(REG_BUTTON_COUNT, {12'd0, count});
        cfg_write(REG_ACTIVE_LEVELS, {8'd0, levels});
        cfg_write(REG_SCAN_INTERVAL, {8'd0, step});
        cfg_write(REG_LONG_PRESS_DELAY, delay_val);
        if (spare)
            cfg_write(REG_SPARE, 16'hFFFF);
        cfg_we <= 1'b0;
    endtask

    // mostly held buttons with the odd edge, sometimes a fully random tick
    function automatic logic [7:0] next_pins();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return prev_pins ^ 8'($urandom & $urandom & $urandom);
    endfunction

    initial
    begin
        logic [3:0]  count;
        logic [7:0]  step;
        logic [15:0] delay_val;
        int          r;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: level 0 means pressed, all eight buttons in use
        no_gaps = 1'b1;
        send_tick(8'hFF);   // nothing pressed, no events
        send_tick(8'h00);   // press on all eight
        send_tick(8'h00);   // held, counters grow, no events
        send_tick(8'h0F);   // low half released, high half held
        send_tick(8'hFF);   // rest released

        // three buttons, fast long press; upper buttons stay frozen
        no_gaps = 1'b0;
        apply_config(4'd3, 8'hA5, 8'd1, 16'd2, 1'b1);
        send_tick(8'hA5);   // press on buttons 0..2
        send_tick(8'hA5);   // counters reach 1
        send_tick(8'hA5);   // counters reach delay, long press and clear
        send_tick(8'h5A);   // release, counters kept
        send_tick(8'hA5);   // press again, counters cleared

        // count above eight saturates, zero delay gives long press every tick
        apply_config(4'd15, 8'hFF, 8'd0, 16'd0, 1'b0);
        send_tick(8'hFF);
        send_tick(8'hFF);
        send_tick(8'hFF);
        send_tick(8'h00);

        // no buttons in use, no events whatever the pins
        apply_config(4'd0, 8'h00, 8'd255, 16'd1, 1'b0);
        send_tick(8'h00);
        send_tick(8'hFF);

        // zero interval: held counter never grows, no long press
        apply_config(4'd8, 8'h00, 8'd0, 16'd1, 1'b0);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'h00);

        // widest interval and delay, single button
        apply_config(4'd1, 8'h55, 8'd255, 16'hFFFF, 1'b0);
        send_tick(8'h55);
        send_tick(8'h54);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                count = 4'd8;
            else if (r < 7)
                count = 4'($urandom_range(9, 15));
            else
                count = 4'($urandom_range(0, 7));
            r = $urandom_range(0, 9);
            if (r == 0)
                step = 8'd0;
            else if (r == 1)
                step = 8'd255;
            else
                step = 8'($urandom_range(1, 255));
            // delay mostly a few intervals so long presses keep coming
            r = $urandom_range(0, 9);
            if (r == 0)
                delay_val = 16'hFFFF;
            else if (r == 1)
                delay_val = 16'd0;
            else
                delay_val = 16'($urandom_range(0, int'(step) * 6 + 1));
            apply_config(count, 8'($urandom), step, delay_val, $urandom_range(0, 3) == 0);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int t = 0; t < TICKS_PER_PHASE; t++)
                send_tick(next_pins());
        end

        drain_events();
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
